@@ rtl/swhc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window hit counter package
// Shared types, constants and saturating helpers.
// ----------------------------------------------------------------------------
package swhc_pkg;

   localparam int unsigned BUCKETS_DEFAULT = 512;
   localparam int unsigned TS_W            = 32;
   localparam int unsigned CNT_W           = 32;
   localparam int unsigned WIN_W           = 10;
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(300);
   localparam logic [CNT_W-1:0] CNT_MAX      = '1;

   localparam logic OP_HIT   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic            is_query;
      logic [TS_W-1:0] stamp;
   } item_type;

   typedef struct packed {
      logic [TS_W-1:0]  stamp;
      logic [CNT_W-1:0] hits;
   } bucket_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_APPLY
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
      sat_inc = (a == CNT_MAX) ? a : a + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      sat_sub = (a >= b) ? a - b : '0;
   endfunction

endpackage
`default_nettype wire

@@ rtl/sliding_window_hit_counter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window hit counter
// Counts hits in a sliding window of per-second buckets held in a ring.
//
//   Channel   Ports                                    Direction
//   req       req_valid/ready, req_op, req_timestamp   in
//   rsp       rsp_valid/ready, rsp_hit_count           out
//   csr       csr_wr_en, csr_wr_data                   in, write only
//
// A request passes the idle, read, check and apply states, with another read
// and check per expired bucket evicted; apply follows directly when the ring is
// empty or eviction empties it. The eviction loop reads the ring memory port.
// A two-entry queue sits between front and back; requests are taken while a
// response waits in the output register. Reset is synchronous and empties
// the ring at once; the window returns to 300 seconds.
// ----------------------------------------------------------------------------
module sliding_window_hit_counter_unit #(
   parameter int unsigned BUCKETS = swhc_pkg::BUCKETS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          req_op,
   input  wire logic [31:0]   req_timestamp,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [31:0]        rsp_hit_count,
   input  wire logic          csr_wr_en,
   input  wire logic [9:0]    csr_wr_data
);
   import swhc_pkg::*;

   logic       q_valid;
   logic       q_ready;
   item_type   q_item;

   swhc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_timestamp (req_timestamp),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_item        (q_item)
   );

   swhc_back #(
      .BUCKETS (BUCKETS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_item        (q_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit_count (rsp_hit_count)
   );

endmodule
`default_nettype wire

@@ rtl/swhc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window hit counter front end
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module swhc_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_op,
   input  wire logic [31:0]             req_timestamp,
   output logic                         q_valid,
   input  wire logic                    q_ready,
   output swhc_pkg::item_type           q_item
);
   import swhc_pkg::*;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]          count_ff,  count_in;
   logic                     push, pop;

   assign req_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{is_query: (req_op == OP_QUERY), stamp: req_timestamp};
      end
   end

endmodule
`default_nettype wire

@@ rtl/swhc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window hit counter back end
// Evicts expired buckets from the ring memory, records hits, answers queries.
// ----------------------------------------------------------------------------
module swhc_back #(
   parameter int unsigned BUCKETS = swhc_pkg::BUCKETS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [9:0]              csr_wr_data,
   input  wire logic                    q_valid,
   output logic                         q_ready,
   input  wire swhc_pkg::item_type      q_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [31:0]                  rsp_hit_count
);
   import swhc_pkg::*;

   localparam int unsigned IDX_W = $clog2(BUCKETS);
   localparam int unsigned OCC_W = $clog2(BUCKETS + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUCKETS - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(BUCKETS);

   bucket_type               mem [BUCKETS];

   state_type                state_ff,  state_in;
   item_type                 item_ff,   item_in;
   logic [IDX_W-1:0]         head_ff,   head_in;
   logic [IDX_W-1:0]         tail_ff,   tail_in;
   logic [OCC_W-1:0]         occ_ff,    occ_in;
   logic [CNT_W-1:0]         total_ff,  total_in;
   logic [TS_W-1:0]          newest_stamp_ff, newest_stamp_in;
   logic [CNT_W-1:0]         newest_hits_ff,  newest_hits_in;
   logic [WIN_W-1:0]         window_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   bucket_type               rd_data_ff;

   logic                     rd_en;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   bucket_type               mem_wdata;
   logic [IDX_W-1:0]         head_next, tail_next, newest_idx;
   logic                     expired;
   logic                     ring_full;
   logic [CNT_W-1:0]         base_total;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit_count = rsp_count_ff;

   assign head_next  = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next  = (tail_ff == IDX_LAST) ? '0 : tail_ff + 1'b1;
   assign newest_idx = (tail_ff == '0) ? IDX_LAST : tail_ff - 1'b1;
   assign ring_full  = (occ_ff >= OCC_FULL);
   assign expired    = ({1'b0, rd_data_ff.stamp} + (TS_W+1)'(window_ff))
                       <= {1'b0, item_ff.stamp};

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      occ_in          = occ_ff;
      total_in        = total_ff;
      newest_stamp_in = newest_stamp_ff;
      newest_hits_in  = newest_hits_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_count_in    = rsp_count_ff;
      q_ready         = 1'b0;
      rd_en           = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = tail_ff;
      mem_wdata       = '{stamp: item_ff.stamp, hits: CNT_W'(1)};
      base_total      = ring_full ? sat_sub(total_ff, rd_data_ff.hits) : total_ff;

      unique case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               item_in  = q_item;
               state_in = (occ_ff == '0) ? ST_APPLY : ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // drop the oldest bucket once it has left the window
            if (expired) begin
               total_in = sat_sub(total_ff, rd_data_ff.hits);
               head_in  = head_next;
               occ_in   = occ_ff - 1'b1;
               state_in = (occ_ff == OCC_W'(1)) ? ST_APPLY : ST_READ;
            end else begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (item_ff.is_query) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = total_ff;
                  state_in     = ST_IDLE;
               end
            end else if ((occ_ff != '0) && (newest_stamp_ff == item_ff.stamp)) begin
               newest_hits_in = sat_inc(newest_hits_ff);
               total_in       = sat_inc(total_ff);
               mem_we         = 1'b1;
               mem_waddr      = newest_idx;
               mem_wdata      = '{stamp: item_ff.stamp, hits: sat_inc(newest_hits_ff)};
               state_in       = ST_IDLE;
            end else begin
               // new second: open a bucket, retiring the oldest first when the ring is full
               total_in        = sat_inc(base_total);
               if (ring_full) begin
                  head_in = head_next;
               end else begin
                  occ_in  = occ_ff + 1'b1;
               end
               mem_we          = 1'b1;
               tail_in         = tail_next;
               newest_stamp_in = item_ff.stamp;
               newest_hits_in  = CNT_W'(1);
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         total_ff     <= '0;
         window_ff    <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff         <= item_in;
      newest_stamp_ff <= newest_stamp_in;
      newest_hits_ff  <= newest_hits_in;
      rsp_count_ff    <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("bucket occupancy beyond ring size");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      occ_ff == '0 |-> head_ff == tail_ff)
      else $error("empty ring with unequal head and tail");

   a_check_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> occ_ff != '0)
      else $error("head examined on an empty ring");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_APPLY && item_ff.is_query))
      else $error("response raised outside a query");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window hit counter testbench
// Drives hit and query requests through the valid/ready request channel and
// tracks the window in a local ring of per-second buckets. Every response
// count is checked in order against the predicted window total. Phases cover
// the timestamp extremes, a zero window, a full ring, varying idle and stall
// patterns, and a long response hold-off that backs up the request channel.
// ----------------------------------------------------------------------------
module tb_top;
   import swhc_pkg::*;

   localparam int unsigned RING_DEPTH      = BUCKETS_DEFAULT;
   localparam int unsigned SETTLE_CYCLES   = 2 * RING_DEPTH + 16;
   localparam int unsigned RSP_HOLD_CYCLES = 400;
   localparam int unsigned CYCLE_LIMIT     = 500_000;
   localparam int unsigned REPORT_LIMIT    = 10;

   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic             req_op        = OP_HIT;
   logic [31:0]      req_timestamp = '0;
   logic             rsp_ready     = 1'b0;
   logic             csr_wr_en     = 1'b0;
   logic [WIN_W-1:0] csr_wr_data   = '0;
   logic             req_ready;
   logic             rsp_valid;
   logic [31:0]      rsp_hit_count;

   logic [31:0]      ring_stamp [RING_DEPTH];
   logic [31:0]      ring_hits  [RING_DEPTH];
   int unsigned      ring_first = 0;
   int unsigned      ring_next  = 0;
   int unsigned      ring_used  = 0;
   logic [31:0]      live_total = '0;
   logic [WIN_W-1:0] window_len = WINDOW_RESET;

   logic [31:0]      expected_counts [$];
   int unsigned      error_count     = 0;
   int unsigned      cycle_count     = 0;
   int unsigned      sender_idle_pct = 0;
   int unsigned      rsp_stall_pct   = 0;
   int unsigned      hold_ticket     = 0;
   int unsigned      hold_seen       = 0;
   int unsigned      hold_left       = 0;
   logic [31:0]      stamp_now       = '0;

   always #4 clock = ~clock;

   sliding_window_hit_counter_unit #(
      .BUCKETS(RING_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_timestamp(req_timestamp),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hit_count(rsp_hit_count),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   task automatic drop_oldest_bucket();
      live_total = (live_total >= ring_hits[ring_first]) ?
                   live_total - ring_hits[ring_first] : '0;
      ring_first = (ring_first + 1) % RING_DEPTH;
      ring_used  = ring_used - 1;
   endtask

   task automatic tally_request(input item_type it);
      int unsigned newest;
      while (ring_used != 0 &&
             33'(ring_stamp[ring_first]) + 33'(window_len) <= 33'(it.stamp))
         drop_oldest_bucket();
      if (it.is_query == OP_QUERY) begin
         expected_counts = {expected_counts, live_total};
         return;
      end
      newest = (ring_next + RING_DEPTH - 1) % RING_DEPTH;
      if (ring_used != 0 && ring_stamp[newest] == it.stamp) begin
         if (ring_hits[newest] != CNT_MAX)
            ring_hits[newest] = ring_hits[newest] + 1;
      end else begin
         if (ring_used >= RING_DEPTH)
            drop_oldest_bucket();
         ring_stamp[ring_next] = it.stamp;
         ring_hits[ring_next]  = 1;
         ring_next = (ring_next + 1) % RING_DEPTH;
         ring_used = ring_used + 1;
      end
      if (live_total != CNT_MAX)
         live_total = live_total + 1;
   endtask

   task automatic send_request(input logic op, input logic [31:0] stamp);
      item_type it;
      it.is_query = op;
      it.stamp    = stamp;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= it.is_query;
      req_timestamp <= it.stamp;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      tally_request(it);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_counts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [WIN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      window_len = value;
   endtask

   task automatic random_requests(input int unsigned count, input int unsigned max_step,
                                  input int unsigned query_pct,
                                  input int unsigned repeat_pct,
                                  input int unsigned jump_pct);
      int unsigned roll;
      logic        op;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 2)
            stamp_now = stamp_now - $urandom_range(3 * max_step + 1);
         else if (roll < 2 + jump_pct)
            stamp_now = $urandom;
         else if ($urandom_range(99) >= repeat_pct)
            stamp_now = stamp_now + $urandom_range(max_step, 1);
         op = ($urandom_range(99) < query_pct) ? OP_QUERY : OP_HIT;
         send_request(op, stamp_now);
      end
   endtask

   task automatic test_basic_counting();
      send_request(OP_QUERY, 32'd0);
      send_request(OP_HIT, 32'd0);
      send_request(OP_HIT, 32'd0);
      send_request(OP_HIT, 32'd1);
      send_request(OP_QUERY, 32'd1);
      send_request(OP_QUERY, 32'd299);
      send_request(OP_QUERY, 32'd300);
      send_request(OP_QUERY, 32'd301);
      settle();
   endtask

   task automatic test_stamp_extremes();
      send_request(OP_HIT, 32'hFFFF_FF00);
      send_request(OP_HIT, 32'hFFFF_FFFF);
      send_request(OP_HIT, 32'hFFFF_FFFF);
      send_request(OP_QUERY, 32'hFFFF_FFFF);
      send_request(OP_HIT, 32'd0);
      send_request(OP_HIT, 32'd5);
      send_request(OP_QUERY, 32'd5);
      settle();
   endtask

   task automatic test_zero_window();
      write_window('0);
      send_request(OP_QUERY, 32'hFFFF_FFFF);
      send_request(OP_HIT, 32'd7);
      send_request(OP_QUERY, 32'd7);
      send_request(OP_HIT, 32'd7);
      send_request(OP_HIT, 32'd8);
      send_request(OP_QUERY, 32'd8);
      settle();
   endtask

   task automatic test_single_second_window();
      write_window(WIN_W'(1));
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      stamp_now = $urandom_range(1000);
      random_requests(70, 2, 30, 30, 2);
      settle();
   endtask

   task automatic test_sender_gaps();
      write_window(WIN_W'($urandom_range(511, 2)));
      sender_idle_pct = 80;
      rsp_stall_pct   = 0;
      stamp_now = 32'hFFFF_FF00 + $urandom_range(200);
      random_requests(70, 60, 30, 20, 3);
      settle();
   endtask

   task automatic test_full_ring();
      write_window('1);
      sender_idle_pct = 0;
      rsp_stall_pct   = 80;
      stamp_now = $urandom_range(1000);
      random_requests(640, 1, 6, 10, 0);
      // expire the whole ring in one go
      stamp_now = stamp_now + 2000;
      send_request(OP_QUERY, stamp_now);
      settle();
   endtask

   task automatic test_mixed_idling();
      write_window(WIN_W'(RING_DEPTH));
      sender_idle_pct = 37;
      rsp_stall_pct   = 37;
      stamp_now = $urandom_range(1000);
      random_requests(70, 8, 30, 25, 2);
      settle();
   endtask

   task automatic test_output_backpressure();
      write_window(WINDOW_RESET);
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      hold_ticket <= hold_ticket + 1;
      for (int i = 0; i < 24; i++) begin
         stamp_now = stamp_now + $urandom_range(1);
         send_request(($urandom_range(3) == 0) ? OP_HIT : OP_QUERY, stamp_now);
      end
      settle();
   endtask

   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= RSP_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (error_count < REPORT_LIMIT)
         $display("mismatch at cycle %0d: %s, hit_count expected %0d got %0d",
                  cycle_count, what, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin : check_response
      logic [31:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_counts.size() == 0) begin
            note_mismatch("response with no request pending", 'x, rsp_hit_count);
         end else begin
            want = expected_counts[0];
            expected_counts.delete(0);
            if (rsp_hit_count !== want)
               note_mismatch("wrong window count", want, rsp_hit_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_counting();
      test_stamp_extremes();
      test_zero_window();
      test_single_second_window();
      test_sender_gaps();
      test_full_ring();
      test_mixed_idling();
      test_output_backpressure();
      if (error_count == 0 && expected_counts.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/swhc_pkg.sv
rtl/swhc_front.sv
rtl/swhc_back.sv
rtl/sliding_window_hit_counter_unit.sv
tb/tb_top.sv
